FILE: rtl/core/gcbc_pkg.sv
// gcbc_pkg: shared types and constants for the glyph coverage blend/clip core
// used by the front, queue, back and top files under rtl/core, no dependencies of its own
package gcbc_pkg;

    // register indexes on the configuration channel
    typedef enum logic [2:0] {
        REG_CLIP_LEFT    = 3'd0,
        REG_CLIP_TOP     = 3'd1,
        REG_CLIP_RIGHT   = 3'd2,
        REG_CLIP_LOWER   = 3'd3,
        REG_BUFFER_ROWS  = 3'd4,
        REG_TEXT_COLOR   = 3'd5,
        REG_WIDE_PIXELS  = 3'd6,
        REG_HIDE_PARTIAL = 3'd7
    } t_reg_idx;

    localparam logic [13:0] EDGE_RESET  = 14'd8192;

    // blend masks and coverage codes
    localparam logic [15:0] MASK565_RB     = 16'hF81F;
    localparam logic [15:0] MASK565_G      = 16'h07E0;
    localparam logic [23:0] MASK32_RB      = 24'hFF00FF;
    localparam logic [23:0] MASK32_G       = 24'h00FF00;
    localparam logic [6:0]  COV_FULL_WIDE  = 7'h78;
    localparam logic [6:0]  COV_MAX_WIDE   = 7'h7F;
    localparam logic [3:0]  COV_MAX_NARROW = 4'hF;

    // depth of the queue between classifier and blender
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [13:0] clip_left;
        logic [13:0] clip_top;
        logic [13:0] clip_right;
        logic [13:0] clip_lower;
        logic [13:0] buffer_rows;
        logic [31:0] text_color;
        logic        wide_pixels;
        logic        hide_partial;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] glyph_x;
        logic signed [15:0] glyph_y;
        logic [8:0]         glyph_width;
        logic [8:0]         glyph_height;
        logic [7:0]         column;
        logic [7:0]         row;
        logic [7:0]         coverage;
        logic [31:0]        dest_pixel;
    } t_in;

    typedef struct packed {
        logic        write_enable;
        logic [12:0] pixel_x;
        logic [12:0] pixel_y;
        logic [31:0] pixel_value;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        logic        visible;
        logic [12:0] px;
        logic [12:0] py;
        logic [7:0]  coverage;
        logic [31:0] dest;
    } t_item;

endpackage

FILE: rtl/core/gcbc_if.sv
// gcbc_if: valid/ready stream channel and configuration write channel
// payload type of the stream comes in as a type parameter, no other dependencies
interface gcbc_stream_if #(parameter type T = logic [0:0]);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gcbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/gcbc_front.sv
// gcbc_front: accepts coverage pixels and classifies them against the clip window
// depends on gcbc_pkg and gcbc_stream_if
module gcbc_front import gcbc_pkg::*; #(
    parameter int MAX_GLYPH = 256,
    parameter int FRAME_DIM = 8192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    gcbc_stream_if.sink   i_in,
    output logic          o_valid,
    output t_item         o_item,
    input  logic          i_ready
);

    localparam int SW = 18;
    localparam logic signed [SW-1:0] FRAME_S = SW'(FRAME_DIM);

    logic                 r_valid;
    t_item                r_item;
    t_item                n_item;

    logic [8:0]           gw;
    logic [8:0]           gh;
    logic signed [SW-1:0] gx_s, gy_s, gh_s, col_s, row_s;
    logic signed [SW-1:0] cl_s, ct_s, cr_s, cb_s, rows_s;
    logic signed [SW-1:0] px, py, ybot, ytop, hgt, half;
    logic                 col_ok, row_ok, x_ok, y_ok, frame_ok, top_cut, bot_cut, drop;

    assign gw = (i_in.data.glyph_width > MAX_GLYPH) ? 9'(MAX_GLYPH) : i_in.data.glyph_width;
    assign gh = (i_in.data.glyph_height > MAX_GLYPH) ? 9'(MAX_GLYPH) : i_in.data.glyph_height;

    assign gx_s   = SW'(i_in.data.glyph_x);
    assign gy_s   = SW'(i_in.data.glyph_y);
    assign gh_s   = SW'(gh);
    assign col_s  = SW'(i_in.data.column);
    assign row_s  = SW'(i_in.data.row);
    assign cl_s   = SW'(i_cfg.clip_left);
    assign ct_s   = SW'(i_cfg.clip_top);
    assign cr_s   = SW'(i_cfg.clip_right);
    assign cb_s   = SW'(i_cfg.clip_lower);
    assign rows_s = SW'(i_cfg.buffer_rows);

    assign px   = gx_s + col_s;
    assign py   = gy_s + row_s;
    assign ybot = gy_s + gh_s;
    assign ytop = (gy_s < ct_s) ? ct_s : gy_s;
    // visible height left after a cut at the top
    assign hgt  = ybot - ytop;
    assign half = gh_s >>> 1;

    assign col_ok   = {1'b0, i_in.data.column} < gw;
    assign row_ok   = {1'b0, i_in.data.row} < gh;
    assign x_ok     = (px >= cl_s) && (px < cr_s);
    assign top_cut  = gy_s < ct_s;
    assign bot_cut  = ybot > cb_s;
    assign drop     = i_cfg.hide_partial && (top_cut || bot_cut) && (hgt <= half);
    // with hiding on, the clip bottom gives way to the buffer height
    assign y_ok     = (py >= ct_s) && (i_cfg.hide_partial || (py < cb_s)) && (py < rows_s);
    assign frame_ok = (px < FRAME_S) && (py < FRAME_S) && !px[SW-1] && !py[SW-1];

    always_comb begin
        n_item.visible  = col_ok && row_ok && x_ok && y_ok && frame_ok && !drop;
        n_item.px       = px[12:0];
        n_item.py       = py[12:0];
        n_item.coverage = i_in.data.coverage;
        n_item.dest     = i_in.data.dest_pixel;
    end

    assign i_in.ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/core/gcbc_queue.sv
// gcbc_queue: short first-in first-out queue of classified items
// depends on gcbc_pkg for the item type and depth
module gcbc_queue import gcbc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not shrink on pop");

    a_ptrs_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(QUEUE_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers out of step with count");

endmodule

FILE: rtl/core/gcbc_back.sv
// gcbc_back: blends the text color into visible pixels and holds the result register
// depends on gcbc_pkg and gcbc_stream_if
module gcbc_back import gcbc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  logic           i_valid,
    input  t_item          i_item,
    output logic           o_ready,
    gcbc_stream_if.source  o_out
);

    logic        r_valid;
    t_out        r_out;
    t_out        n_out;

    logic [15:0] t565;
    logic [15:0] d565;
    logic [3:0]  c4;
    logic [3:0]  a4;
    logic [19:0] nrb;
    logic [19:0] ng;
    logic [15:0] narrow_px;
    logic [6:0]  c7;
    logic [6:0]  a7;
    logic [30:0] wrb;
    logic [30:0] wg;
    logic [31:0] wide_px;

    // narrow mode keeps the top 5/6/5 bits of each channel
    assign t565 = {i_cfg.text_color[23:19], i_cfg.text_color[15:10], i_cfg.text_color[7:3]};
    assign d565 = i_item.dest[15:0];
    assign c4   = i_item.coverage[7:4];
    assign a4   = COV_MAX_NARROW - c4;
    assign nrb  = 20'(a4) * 20'(d565 & MASK565_RB) + 20'(c4) * 20'(t565 & MASK565_RB);
    assign ng   = 20'(a4) * 20'(d565 & MASK565_G) + 20'(c4) * 20'(t565 & MASK565_G);

    always_comb begin
        if (c4 == COV_MAX_NARROW) begin
            narrow_px = t565;
        end else if (c4 == '0) begin
            narrow_px = d565;
        end else begin
            narrow_px = (nrb[19:4] & MASK565_RB) | (ng[19:4] & MASK565_G);
        end
    end

    assign c7  = i_item.coverage[7:1];
    assign a7  = COV_MAX_WIDE - c7;
    assign wrb = 31'(a7) * 31'(i_item.dest[23:0] & MASK32_RB)
               + 31'(c7) * 31'(i_cfg.text_color[23:0] & MASK32_RB);
    assign wg  = 31'(a7) * 31'(i_item.dest[23:0] & MASK32_G)
               + 31'(c7) * 31'(i_cfg.text_color[23:0] & MASK32_G);

    always_comb begin
        if (c7 >= COV_FULL_WIDE) begin
            wide_px = i_cfg.text_color;
        end else if (c7 == '0) begin
            wide_px = i_item.dest;
        end else begin
            // top byte drops out of the blend
            wide_px = {8'h00, (wrb[30:7] & MASK32_RB) | (wg[30:7] & MASK32_G)};
        end
    end

    always_comb begin
        n_out = '0;
        if (i_item.visible) begin
            n_out.write_enable = 1'b1;
            n_out.pixel_x      = i_item.px;
            n_out.pixel_y      = i_item.py;
            n_out.pixel_value  = i_cfg.wide_pixels ? wide_px : {16'h0000, narrow_px};
        end
    end

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_out;

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_out.write_enable |->
            r_out.pixel_x == '0 && r_out.pixel_y == '0 && r_out.pixel_value == '0)
        else $error("hidden pixel carries nonzero fields");

    a_narrow_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_cfg.wide_pixels |=> r_out.pixel_value[31:16] == '0)
        else $error("narrow pixel has upper bits set");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_valid)
        else $error("result register missed an item");

endmodule

FILE: rtl/core/glyph_coverage_blend_clip_core.sv
// glyph_coverage_blend_clip_core: top level, configuration registers and the three stages
// depends on gcbc_pkg, gcbc_if, gcbc_front, gcbc_queue, gcbc_back
//
//   channel  dir  handshake          payload
//   i_in     in   valid/ready        glyph origin, size, column, row, coverage, dest pixel
//   o_out    out  valid/ready        write_enable, pixel_x, pixel_y, pixel_value
//   i_cfg    in   valid/ready        register index (3 bits), write data (32 bits)
//
// one item per cycle sustained while o_out is ready; an accepted item passes through
// the classify register, a queue entry and the result register before it shows on o_out
// synchronous active-low reset clears all valid flags and loads register defaults
// a stall at o_out fills the result register, then the four-entry queue, then the
// classify register before i_in.ready drops; configuration writes are always taken
module glyph_coverage_blend_clip_core import gcbc_pkg::*; #(
    parameter int MAX_GLYPH = 256,
    parameter int FRAME_DIM = 8192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gcbc_stream_if.sink   i_in,
    gcbc_stream_if.source o_out,
    gcbc_cfg_if.sink      i_cfg
);

    t_cfg  r_cfg;
    logic  front_valid;
    t_item front_item;
    logic  queue_ready;
    logic  queue_valid;
    t_item queue_item;
    logic  back_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left    <= '0;
            r_cfg.clip_top     <= '0;
            r_cfg.clip_right   <= EDGE_RESET;
            r_cfg.clip_lower   <= EDGE_RESET;
            r_cfg.buffer_rows  <= EDGE_RESET;
            r_cfg.text_color   <= '0;
            r_cfg.wide_pixels  <= 1'b1;
            r_cfg.hide_partial <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_CLIP_LEFT:    r_cfg.clip_left    <= i_cfg.wdata[13:0];
                REG_CLIP_TOP:     r_cfg.clip_top     <= i_cfg.wdata[13:0];
                REG_CLIP_RIGHT:   r_cfg.clip_right   <= i_cfg.wdata[13:0];
                REG_CLIP_LOWER:   r_cfg.clip_lower   <= i_cfg.wdata[13:0];
                REG_BUFFER_ROWS:  r_cfg.buffer_rows  <= i_cfg.wdata[13:0];
                REG_TEXT_COLOR:   r_cfg.text_color   <= i_cfg.wdata;
                REG_WIDE_PIXELS:  r_cfg.wide_pixels  <= i_cfg.wdata[0];
                REG_HIDE_PARTIAL: r_cfg.hide_partial <= i_cfg.wdata[0];
            endcase
        end
    end

    gcbc_front #(
        .MAX_GLYPH (MAX_GLYPH),
        .FRAME_DIM (FRAME_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_ready (queue_ready)
    );

    gcbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_ready (back_ready)
    );

    gcbc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .i_item  (queue_item),
        .o_ready (back_ready),
        .o_out   (o_out)
    );

endmodule
